// ===== hdl/packet_check_and_ack_builder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet check and acknowledge builder.
// Both macros sample on the rising clock edge and are held off during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_CHECK_AND_ACK_BUILDER_TOP_ASSERT_SVH
`define PACKET_CHECK_AND_ACK_BUILDER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCAB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pcab_pkg.sv =====
// ----------------------------------------------------------------------------
// pcab_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte step shared by the
// packet check and acknowledge builder.
// ----------------------------------------------------------------------------
package pcab_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } pcab_in_t;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         ack_byte;
    logic [7:0]         sequence_res;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic signed [15:0] weight;
    logic               duplicate;
    logic               run_end;
  } pcab_out_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MAGIC_VALUE      = 3'd0,
    CFG_PROTOCOL_VERSION = 3'd1,
    CFG_DATA_KIND        = 3'd2,
    CFG_ACK_KIND         = 3'd3,
    CFG_GATEWAY_ADDRESS  = 3'd4
  } pcab_cfg_e;

  // Position of the next result within the burst after a good packet.
  typedef enum logic [3:0] {
    SLOT_MAGIC    = 4'd0,
    SLOT_VERSION  = 4'd1,
    SLOT_ACK_KIND = 4'd2,
    SLOT_GATEWAY  = 4'd3,
    SLOT_SEQUENCE = 4'd4,
    SLOT_PAD      = 4'd5,
    SLOT_CRC_HI   = 4'd6,
    SLOT_CRC_LO   = 4'd7,
    SLOT_RECORD   = 4'd8
  } pcab_slot_e;

  localparam logic        RESULT_ACK    = 1'b0;
  localparam logic        RESULT_RECORD = 1'b1;

  localparam logic [7:0]  MAGIC_RESET    = 8'hA5;
  localparam logic [7:0]  VERSION_RESET  = 8'h01;
  localparam logic [7:0]  DATA_KIND_RST  = 8'h10;
  localparam logic [7:0]  ACK_KIND_RST   = 8'h20;
  localparam logic [7:0]  GATEWAY_RESET  = 8'hF0;
  localparam logic [7:0]  ACK_PAD_BYTE   = 8'h00;
  localparam logic [7:0]  SEQ_RESET      = 8'hFF;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  localparam int unsigned COUNT_W        = 7;
  localparam logic [COUNT_W-1:0] COUNT_CAP = 7'd127;
  // A good packet holds at least this many bytes.
  localparam int unsigned MIN_LEN        = 8;
  localparam int unsigned PAY_FIRST      = 6;
  localparam int unsigned PAY_BYTES      = 6;
  localparam logic [COUNT_W-1:0] IDX_MAGIC   = 7'd0;
  localparam logic [COUNT_W-1:0] IDX_VERSION = 7'd1;
  localparam logic [COUNT_W-1:0] IDX_KIND    = 7'd2;
  localparam logic [COUNT_W-1:0] IDX_SEQ     = 7'd4;

  // One byte through CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/packet_check_and_ack_builder_top.sv =====
// ----------------------------------------------------------------------------
// packet_check_and_ack_builder_top
// Checks framed packets (header bytes, length, CRC-16/CCITT-FALSE) and, for a
// good packet, sends an 8-byte acknowledge frame and one reading record.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  in_data_i   (pcab_in_t)
//  out      output     out_valid_o / out_stall_i out_data_o (pcab_out_t)
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle unless stalled; the CRC steps a byte at once.
// The last byte of a good packet starts a burst of nine results, one per
// cycle unless the output stalls, from the output register; the input is
// stalled until the record has been loaded.
// Reset is asynchronous and resets all but the snapshot and output data.
// A stall on the output holds the output register and stretches the burst.
// ----------------------------------------------------------------------------
module packet_check_and_ack_builder_top
  import pcab_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pcab_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pcab_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam logic [COUNT_W-1:0] MaxIdx = COUNT_W'(MAX_PACKET_BYTES);
  localparam logic [COUNT_W-1:0] LastMinIdx = COUNT_W'(MIN_LEN - 1);

  // Configuration registers.
  logic [7:0] magic_q, version_q, data_kind_q, ack_kind_q, gateway_q;

  // Per-packet state.
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]        crc_q, crc_d;
  logic [7:0]         held_q [2];
  logic               hdr_ok_q, hdr_ok_d;
  logic [7:0]         seq_q, seq_d;
  logic [7:0]         pay_q [PAY_BYTES];
  logic [7:0]         pay_d [PAY_BYTES];
  logic [7:0]         last_seq_q;

  // Burst snapshot and sequencer.
  logic               burst_q;
  pcab_slot_e         slot_q;
  logic [15:0]        ack_crc_q, ack_crc_d;
  logic [7:0]         snap_seq_q;
  logic [7:0]         snap_pay_q [PAY_BYTES];
  logic               snap_dup_q;

  // Output register.
  logic               out_valid_q;
  pcab_out_t          out_data_q, next_res;

  logic in_xfer, pkt_good, load;
  logic [7:0] ack_b;

  assign in_stall_o  = burst_q;
  assign in_xfer     = in_valid_i && !burst_q;
  assign load        = burst_q && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Per-byte update of the packet state.
  always_comb begin
    hdr_ok_d = hdr_ok_q;
    if (cnt_q >= MaxIdx) hdr_ok_d = 1'b0;
    if (cnt_q == IDX_MAGIC   && in_data_i.rx_byte != magic_q)     hdr_ok_d = 1'b0;
    if (cnt_q == IDX_VERSION && in_data_i.rx_byte != version_q)   hdr_ok_d = 1'b0;
    if (cnt_q == IDX_KIND    && in_data_i.rx_byte != data_kind_q) hdr_ok_d = 1'b0;
    seq_d = (cnt_q == IDX_SEQ) ? in_data_i.rx_byte : seq_q;
    for (int i = 0; i < PAY_BYTES; i++) begin
      pay_d[i] = (cnt_q == COUNT_W'(PAY_FIRST + i)) ? in_data_i.rx_byte : pay_q[i];
    end
    // The two newest bytes stay in the hold and never reach the CRC.
    crc_d = (cnt_q >= IDX_KIND) ? crc_feed(crc_q, held_q[0]) : crc_q;
    cnt_d = (cnt_q < COUNT_CAP) ? cnt_q + COUNT_W'(1) : cnt_q;
    pkt_good = in_data_i.last_byte && (cnt_q >= LastMinIdx) && hdr_ok_d &&
               (crc_d == {held_q[1], in_data_i.rx_byte});
  end

  // Next result of the burst.
  always_comb begin
    case (slot_q)
      SLOT_MAGIC:    ack_b = magic_q;
      SLOT_VERSION:  ack_b = version_q;
      SLOT_ACK_KIND: ack_b = ack_kind_q;
      SLOT_GATEWAY:  ack_b = gateway_q;
      SLOT_SEQUENCE: ack_b = snap_seq_q;
      SLOT_PAD:      ack_b = ACK_PAD_BYTE;
      SLOT_CRC_HI:   ack_b = ack_crc_q[15:8];
      SLOT_CRC_LO:   ack_b = ack_crc_q[7:0];
      default:       ack_b = 8'h00;
    endcase
    ack_crc_d = (slot_q < SLOT_CRC_HI) ? crc_feed(ack_crc_q, ack_b) : ack_crc_q;
    next_res = '0;
    if (slot_q == SLOT_RECORD) begin
      next_res.result_kind  = RESULT_RECORD;
      next_res.sequence_res = snap_seq_q;
      next_res.temperature  = {snap_pay_q[1], snap_pay_q[0]};
      next_res.humidity     = {snap_pay_q[3], snap_pay_q[2]};
      next_res.weight       = {snap_pay_q[5], snap_pay_q[4]};
      next_res.duplicate    = snap_dup_q;
      next_res.run_end      = 1'b1;
    end else begin
      next_res.result_kind  = RESULT_ACK;
      next_res.ack_byte     = ack_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= MAGIC_RESET;
      version_q   <= VERSION_RESET;
      data_kind_q <= DATA_KIND_RST;
      ack_kind_q  <= ACK_KIND_RST;
      gateway_q   <= GATEWAY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC_VALUE:      magic_q     <= cfg_wdata_i;
        CFG_PROTOCOL_VERSION: version_q   <= cfg_wdata_i;
        CFG_DATA_KIND:        data_kind_q <= cfg_wdata_i;
        CFG_ACK_KIND:         ack_kind_q  <= cfg_wdata_i;
        CFG_GATEWAY_ADDRESS:  gateway_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      crc_q      <= CRC_INIT;
      held_q[0]  <= '0;
      held_q[1]  <= '0;
      hdr_ok_q   <= 1'b1;
      seq_q      <= '0;
      for (int i = 0; i < PAY_BYTES; i++) pay_q[i] <= '0;
      last_seq_q <= SEQ_RESET;
    end else if (in_xfer) begin
      if (in_data_i.last_byte) begin
        cnt_q     <= '0;
        crc_q     <= CRC_INIT;
        held_q[0] <= '0;
        held_q[1] <= '0;
        hdr_ok_q  <= 1'b1;
        seq_q     <= '0;
        for (int i = 0; i < PAY_BYTES; i++) pay_q[i] <= '0;
        if (pkt_good) last_seq_q <= seq_d;
      end else begin
        cnt_q     <= cnt_d;
        crc_q     <= crc_d;
        held_q[0] <= held_q[1];
        held_q[1] <= in_data_i.rx_byte;
        hdr_ok_q  <= hdr_ok_d;
        seq_q     <= seq_d;
        pay_q     <= pay_d;
      end
    end
  end

  // Burst sequencer; the snapshot needs no reset since burst_q guards it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q   <= 1'b0;
      slot_q    <= SLOT_MAGIC;
      ack_crc_q <= CRC_INIT;
    end else if (in_xfer && pkt_good) begin
      burst_q   <= 1'b1;
      slot_q    <= SLOT_MAGIC;
      ack_crc_q <= CRC_INIT;
    end else if (load) begin
      ack_crc_q <= ack_crc_d;
      if (slot_q == SLOT_RECORD) begin
        burst_q <= 1'b0;
        slot_q  <= SLOT_MAGIC;
      end else begin
        slot_q  <= pcab_slot_e'(slot_q + 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && pkt_good) begin
      snap_seq_q <= seq_d;
      snap_pay_q <= pay_d;
      snap_dup_q <= (seq_d == last_seq_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_data_q <= next_res;
  end

endmodule

// ===== hdl/pcab_checker.sv =====
// ----------------------------------------------------------------------------
// pcab_checker
// Port-level checks on the packet check and acknowledge builder.
// ----------------------------------------------------------------------------
`include "packet_check_and_ack_builder_top_assert.svh"

module pcab_checker
  import pcab_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input pcab_out_t out_data_o
);

  logic ack_shown, rec_shown;

  assign ack_shown = out_valid_o && (out_data_o.result_kind == RESULT_ACK);
  assign rec_shown = out_valid_o && (out_data_o.result_kind == RESULT_RECORD);

  `PCAB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `PCAB_ASSERT_SAME(a_ack_clean, ack_shown, !out_data_o.run_end && !out_data_o.duplicate && out_data_o.sequence_res == 8'h00, "ack byte carries record fields")
  `PCAB_ASSERT_SAME(a_rec_end, rec_shown, out_data_o.run_end && out_data_o.ack_byte == 8'h00, "record without run end")
  // Until the record is loaded, no new packet byte may enter.
  `PCAB_ASSERT_SAME(a_ack_blocks_in, ack_shown, in_stall_o, "input open during ack frame")

endmodule

bind packet_check_and_ack_builder_top pcab_checker u_pcab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== verif/packet_check_and_ack_builder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_check_and_ack_builder_top_tb
// Sends framed packets byte by byte under random gaps and output stalls. A
// byte-level copy of the packet checker predicts every acknowledge byte and
// reading record, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
module packet_check_and_ack_builder_top_tb;
  import pcab_pkg::*;

  localparam int unsigned PKT_MAX       = 64;
  localparam int unsigned ACK_LEN       = 8;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef logic [7:0] octet_q_t [$];

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  pcab_in_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_idx   = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_stall;
  logic       out_valid;
  pcab_out_t  out_data;

  packet_check_and_ack_builder_top #(
    .MAX_PACKET_BYTES(PKT_MAX)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  // Shadow of the checker state and registers.
  logic [7:0]         cfg_shadow [5];
  logic [COUNT_W-1:0] rx_count;
  logic [15:0]        rx_crc;
  logic [7:0]         held [2];
  logic               hdr_good;
  logic [7:0]         rx_seq;
  logic [7:0]         pay [PAY_BYTES];
  logic [7:0]         last_good_seq;

  pcab_out_t   ack_record_q [$];
  int unsigned err_count  = 0;
  int unsigned stall_left = 0;
  bit          gaps_on    = 1'b1;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ d[i];
      crc = crc << 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function void clear_packet_state();
    rx_count = '0;
    rx_crc   = CRC_INIT;
    held[0]  = '0;
    held[1]  = '0;
    hdr_good = 1'b1;
    rx_seq   = '0;
    foreach (pay[i]) pay[i] = '0;
  endfunction

  // Advances the shadow by one accepted byte and queues the burst that a good
  // packet produces on its last byte.
  function void absorb_rx_byte(logic [7:0] b, logic last);
    int unsigned pos;
    logic [7:0]  frame [ACK_LEN];
    logic [15:0] fcrc;
    pcab_out_t   r;
    pos = rx_count;
    if (pos >= PKT_MAX) hdr_good = 1'b0;
    if (rx_count == IDX_MAGIC && b != cfg_shadow[CFG_MAGIC_VALUE]) hdr_good = 1'b0;
    if (rx_count == IDX_VERSION && b != cfg_shadow[CFG_PROTOCOL_VERSION]) hdr_good = 1'b0;
    if (rx_count == IDX_KIND && b != cfg_shadow[CFG_DATA_KIND]) hdr_good = 1'b0;
    if (rx_count == IDX_SEQ) rx_seq = b;
    if (pos >= PAY_FIRST && pos < PAY_FIRST + PAY_BYTES) pay[pos - PAY_FIRST] = b;
    // The CRC trails the input by two bytes so that the final two stay out.
    if (pos >= 2) rx_crc = crc16_step(rx_crc, held[0]);
    held[0] = held[1];
    held[1] = b;
    if (rx_count != COUNT_CAP) rx_count++;
    if (!last) return;
    if (pos + 1 >= MIN_LEN && hdr_good && rx_crc == {held[0], held[1]}) begin
      frame[SLOT_MAGIC]    = cfg_shadow[CFG_MAGIC_VALUE];
      frame[SLOT_VERSION]  = cfg_shadow[CFG_PROTOCOL_VERSION];
      frame[SLOT_ACK_KIND] = cfg_shadow[CFG_ACK_KIND];
      frame[SLOT_GATEWAY]  = cfg_shadow[CFG_GATEWAY_ADDRESS];
      frame[SLOT_SEQUENCE] = rx_seq;
      frame[SLOT_PAD]      = ACK_PAD_BYTE;
      fcrc = CRC_INIT;
      for (int k = 0; k < SLOT_CRC_HI; k++) fcrc = crc16_step(fcrc, frame[k]);
      frame[SLOT_CRC_HI] = fcrc[15:8];
      frame[SLOT_CRC_LO] = fcrc[7:0];
      for (int k = 0; k < ACK_LEN; k++) begin
        r             = '0;
        r.result_kind = RESULT_ACK;
        r.ack_byte    = frame[k];
        ack_record_q.push_back(r);
      end
      r              = '0;
      r.result_kind  = RESULT_RECORD;
      r.sequence_res = rx_seq;
      r.temperature  = {pay[1], pay[0]};
      r.humidity     = {pay[3], pay[2]};
      r.weight       = {pay[5], pay[4]};
      r.duplicate    = (rx_seq == last_good_seq);
      r.run_end      = 1'b1;
      ack_record_q.push_back(r);
      last_good_seq = rx_seq;
    end
    clear_packet_state();
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    pcab_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (ack_record_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          err_count++;
        end else begin
          want = ack_record_q.pop_front();
          compare_field("result_kind", 16'(want.result_kind), 16'(out_data.result_kind));
          compare_field("ack_byte", 16'(want.ack_byte), 16'(out_data.ack_byte));
          compare_field("sequence_res", 16'(want.sequence_res),
                        16'(out_data.sequence_res));
          compare_field("temperature", want.temperature, out_data.temperature);
          compare_field("humidity", want.humidity, out_data.humidity);
          compare_field("weight", want.weight, out_data.weight);
          compare_field("duplicate", 16'(want.duplicate), 16'(out_data.duplicate));
          compare_field("run_end", 16'(want.run_end), 16'(out_data.run_end));
        end
        stall_left = gaps_on ? $urandom_range(0, 5) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    absorb_rx_byte(b, last);
  endtask

  task automatic send_frame(octet_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // Header taken from the current registers, the sequence in its slot and
  // random bytes elsewhere; bad_header corrupts one of the first three bytes.
  function automatic octet_q_t frame_body(int unsigned n, logic [7:0] seq, bit bad_header);
    octet_q_t   f;
    logic [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == IDX_MAGIC) b = cfg_shadow[CFG_MAGIC_VALUE];
      else if (i == IDX_VERSION) b = cfg_shadow[CFG_PROTOCOL_VERSION];
      else if (i == IDX_KIND) b = cfg_shadow[CFG_DATA_KIND];
      else if (i == IDX_SEQ) b = seq;
      else b = 8'($urandom);
      f.push_back(b);
    end
    if (bad_header) f[$urandom_range(0, IDX_KIND)] ^= 8'($urandom_range(1, 255));
    return f;
  endfunction

  function automatic octet_q_t add_crc(octet_q_t f);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (f[i]) c = crc16_step(c, f[i]);
    f.push_back(c[15:8]);
    f.push_back(c[7:0]);
    return f;
  endfunction

  function automatic octet_q_t build_frame(int unsigned len, logic [7:0] seq, bit bad_header);
    return add_crc(frame_body(len - 2, seq, bad_header));
  endfunction

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (ack_record_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(logic [7:0] m, logic [7:0] v, logic [7:0] d,
                               logic [7:0] a, logic [7:0] g);
    logic [7:0] vals [5];
    pcab_cfg_e  reg_id;
    vals   = '{m, v, d, a, g};
    reg_id = CFG_MAGIC_VALUE;
    repeat (5) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_id;
      cfg_wdata <= vals[reg_id];
      @(posedge clk);
      cfg_shadow[reg_id] = vals[reg_id];
      reg_id = reg_id.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_frames();
    octet_q_t f;
    // Shortest good frame: bytes 6 and 7 are its CRC and the rest of the
    // payload reads as zero. Sequence 255 repeats the reset sequence.
    f = build_frame(MIN_LEN, 8'hFF, 1'b0);
    send_frame(f);
    // Extreme temperature and humidity, again with a repeated sequence.
    f    = frame_body(10, 8'hFF, 1'b0);
    f[6] = 8'h00;
    f[7] = 8'h80;
    f[8] = 8'hFF;
    f[9] = 8'hFF;
    send_frame(add_crc(f));
    // A lone byte with the last mark is far too short.
    send_byte(8'hFF, 1'b1);
    // A corrupted CRC byte must suppress the whole burst.
    f    = build_frame(MIN_LEN, 8'h00, 1'b0);
    f[7] = f[7] ^ 8'h01;
    send_frame(f);
  endtask

  task automatic test_long_frames();
    send_frame(build_frame(PKT_MAX, 8'($urandom), 1'b0));
    // Long enough for the byte counter to saturate.
    send_frame(build_frame(COUNT_CAP + 3, 8'($urandom), 1'b0));
    send_frame(build_frame(MIN_LEN, 8'($urandom), 1'b0));
  endtask

  task automatic test_random_traffic(int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  seq;
    octet_q_t    f;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
      seq  = ($urandom_range(0, 3) == 0) ? last_good_seq : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        f = build_frame($urandom_range(MIN_LEN, 20), seq, 1'b0);
      end else if (pick < 77) begin
        f = build_frame($urandom_range(MIN_LEN, 20), seq, 1'b0);
        f[$urandom_range(0, f.size() - 1)] ^= 8'($urandom_range(1, 255));
      end else if (pick < 87) begin
        f = build_frame($urandom_range(MIN_LEN, 20), seq, 1'b1);
      end else if (pick < 94) begin
        f = build_frame($urandom_range(2, MIN_LEN - 1), seq, 1'b0);
      end else if (pick < 98) begin
        f = {};
        repeat ($urandom_range(1, 12)) f.push_back(8'($urandom));
      end else begin
        f = build_frame($urandom_range(PKT_MAX + 1, PKT_MAX + 6), seq, 1'b0);
      end
      send_frame(f);
      sent += f.size();
      // Now and then hold the input until every result has come out.
      if ($urandom_range(0, 15) == 0) drain_outputs();
    end
  endtask

  initial begin
    cfg_shadow[CFG_MAGIC_VALUE]      = MAGIC_RESET;
    cfg_shadow[CFG_PROTOCOL_VERSION] = VERSION_RESET;
    cfg_shadow[CFG_DATA_KIND]        = DATA_KIND_RST;
    cfg_shadow[CFG_ACK_KIND]         = ACK_KIND_RST;
    cfg_shadow[CFG_GATEWAY_ADDRESS]  = GATEWAY_RESET;
    last_good_seq = SEQ_RESET;
    clear_packet_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_long_frames();
    test_random_traffic(30);
    drain_outputs();
    set_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    test_random_traffic(30);
    drain_outputs();
    set_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    test_random_traffic(30);
    drain_outputs();
    set_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    test_random_traffic(30);
    drain_outputs();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== packet_check_and_ack_builder_top.f =====
+incdir+hdl
hdl/pcab_pkg.sv
hdl/packet_check_and_ack_builder_top.sv
hdl/pcab_checker.sv
verif/packet_check_and_ack_builder_top_tb.sv
